@@ rtl/xed_pkg.sv @@
// Package: shared types, character codes and entity tables of the entity decoder.
`default_nettype none

package xed_pkg;

	// character codes
	localparam logic [15:0] CH_NUL   = 16'h0000;
	localparam logic [15:0] CH_AMP   = 16'h0026;
	localparam logic [15:0] CH_LT    = 16'h003C;
	localparam logic [15:0] CH_GT    = 16'h003E;
	localparam logic [15:0] CH_QUOT  = 16'h0022;
	localparam logic [15:0] CH_APOS  = 16'h0027;
	localparam logic [15:0] CH_SPACE = 16'h0020;
	localparam logic [15:0] CH_SEMI  = 16'h003B;
	// highest code that counts as whitespace
	localparam logic [15:0] WS_MAX   = 16'h0020;

	// result kinds
	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// entity table sizes
	localparam int ENT_COUNT = 5;
	localparam int BUF_DEPTH = 5;
	localparam int MAX_ITEMS = 6;

	// one result item
	typedef struct packed {
		logic [15:0] ch;
		logic        kind;
	} xed_item_t;

	// all results caused by one input item
	typedef struct packed {
		logic [2:0]                     count;
		xed_item_t [MAX_ITEMS-1:0]      items;
	} xed_cmd_t;

	// character i of entity k (zero past its end)
	function automatic logic [15:0] ent_pat(input logic [2:0] k, input logic [2:0] i);
		logic [15:0] r;
		r = CH_NUL;
		if (i == 3'd0) begin
			r = CH_AMP;
		end else begin
			case (k)
				3'd0: begin
					case (i)
						3'd1: r = 16'h0061; // a
						3'd2: r = 16'h006D; // m
						3'd3: r = 16'h0070; // p
						3'd4: r = CH_SEMI;
						default: r = CH_NUL;
					endcase
				end
				3'd1: begin
					case (i)
						3'd1: r = 16'h006C; // l
						3'd2: r = 16'h0074; // t
						3'd3: r = CH_SEMI;
						default: r = CH_NUL;
					endcase
				end
				3'd2: begin
					case (i)
						3'd1: r = 16'h0067; // g
						3'd2: r = 16'h0074; // t
						3'd3: r = CH_SEMI;
						default: r = CH_NUL;
					endcase
				end
				3'd3: begin
					case (i)
						3'd1: r = 16'h0071; // q
						3'd2: r = 16'h0075; // u
						3'd3: r = 16'h006F; // o
						3'd4: r = 16'h0074; // t
						3'd5: r = CH_SEMI;
						default: r = CH_NUL;
					endcase
				end
				3'd4: begin
					case (i)
						3'd1: r = 16'h0061; // a
						3'd2: r = 16'h0070; // p
						3'd3: r = 16'h006F; // o
						3'd4: r = 16'h0073; // s
						3'd5: r = CH_SEMI;
						default: r = CH_NUL;
					endcase
				end
				default: r = CH_NUL;
			endcase
		end
		return r;
	endfunction

	// full length of entity k
	function automatic logic [2:0] ent_len(input logic [2:0] k);
		logic [2:0] r;
		case (k)
			3'd0: r = 3'd5;
			3'd1: r = 3'd4;
			3'd2: r = 3'd4;
			3'd3: r = 3'd6;
			3'd4: r = 3'd6;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

	// decoded character of entity k
	function automatic logic [15:0] ent_val(input logic [2:0] k);
		logic [15:0] r;
		case (k)
			3'd0: r = CH_AMP;
			3'd1: r = CH_LT;
			3'd2: r = CH_GT;
			3'd3: r = CH_QUOT;
			3'd4: r = CH_APOS;
			default: r = CH_NUL;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/xed_in_if.sv @@
// Interface: text character channel (valid, ready, character and stop character).
`default_nettype none

interface xed_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] in_char;
	logic [15:0] stop_char;

	modport source (output valid, output in_char, output stop_char, input ready);
	modport sink   (input valid, input in_char, input stop_char, output ready);
endinterface

`default_nettype wire

@@ rtl/xed_out_if.sv @@
// Interface: decoded result channel (valid, ready, character, kind and last flag).
`default_nettype none

interface xed_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] out_char;
	logic        kind;
	logic        last;

	modport source (output valid, output out_char, output kind, output last, input ready);
	modport sink   (input valid, input out_char, input kind, input last, output ready);
endinterface

`default_nettype wire

@@ rtl/xed_front.sv @@
// Front end: accepts characters, tracks the entity prefix and builds result commands.
`default_nettype none

module xed_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	xed_in_if.sink             chars,
	input  wire logic          cfg_we,
	input  wire logic          cfg_wdata,
	input  wire logic          q_full,
	output logic               push,
	output xed_pkg::xed_cmd_t  cmd
);
	import xed_pkg::*;

	logic [15:0] buf_q [BUF_DEPTH];
	logic [15:0] nxt_buf [BUF_DEPTH];
	logic [2:0]  len_q, nxt_len;
	logic        skip_q, nxt_skip;
	logic        keep_q;

	logic        accept;
	logic        full, prefix, ok, ended, do_plain;
	logic [15:0] full_val;
	logic [2:0]  n;
	logic [15:0] c, stop;

	assign c      = chars.in_char;
	assign stop   = chars.stop_char;
	assign chars.ready = !q_full;
	assign accept = chars.valid && !q_full;
	assign push   = accept && (n != 3'd0);

	// match the held prefix and the new character against each entity
	always_comb begin
		full     = 1'b0;
		prefix   = 1'b0;
		full_val = CH_NUL;
		for (int k = 0; k < ENT_COUNT; k++) begin
			ok = ent_len(3'(k)) > len_q;
			for (int i = 0; i < BUF_DEPTH; i++) begin
				if (i < int'(len_q) && buf_q[i] != ent_pat(3'(k), 3'(i))) begin
					ok = 1'b0;
				end
			end
			if (ok && ent_pat(3'(k), len_q) == c) begin
				if (ent_len(3'(k)) == len_q + 3'd1) begin
					full     = 1'b1;
					full_val = ent_val(3'(k));
				end else begin
					prefix = 1'b1;
				end
			end
		end
	end

	// build the result list and the next state
	always_comb begin
		cmd      = '0;
		n        = 3'd0;
		nxt_len  = len_q;
		nxt_skip = skip_q;
		nxt_buf  = buf_q;
		ended    = 1'b0;
		do_plain = 1'b0;
		if (len_q == 3'd0) begin
			if (!(skip_q && c != CH_NUL && c <= WS_MAX)) begin
				nxt_skip = 1'b0;
				do_plain = 1'b1;
			end
		end else if (full) begin
			cmd.items[n] = '{ch: full_val, kind: KIND_CHAR};
			n = n + 3'd1;
			nxt_len = 3'd0;
		end else if (prefix && len_q < 3'(BUF_DEPTH)) begin
			nxt_buf[len_q] = c;
			nxt_len = len_q + 3'd1;
		end else begin
			// failed prefix: literal ampersand, then the held characters as text
			nxt_len = 3'd0;
			cmd.items[n] = '{ch: CH_AMP, kind: KIND_CHAR};
			n = n + 3'd1;
			for (int i = 1; i < BUF_DEPTH; i++) begin
				if (i < int'(len_q) && !ended) begin
					if (buf_q[i] == CH_NUL || buf_q[i] == stop) begin
						cmd.items[n] = '{ch: CH_NUL, kind: KIND_END};
						n = n + 3'd1;
						nxt_skip = 1'b0;
						ended = 1'b1;
					end else begin
						cmd.items[n] = '{ch: buf_q[i], kind: KIND_CHAR};
						n = n + 3'd1;
					end
				end
			end
			do_plain = !ended;
		end
		// ordinary handling of the new character
		if (do_plain) begin
			if (c == CH_NUL || c == stop) begin
				cmd.items[n] = '{ch: CH_NUL, kind: KIND_END};
				n = n + 3'd1;
				nxt_len  = 3'd0;
				nxt_skip = 1'b0;
			end else if (c == CH_AMP) begin
				nxt_buf[0] = c;
				nxt_len = 3'd1;
			end else begin
				cmd.items[n] = '{ch: c, kind: KIND_CHAR};
				n = n + 3'd1;
				if (c == CH_SPACE && !keep_q) begin
					nxt_skip = 1'b1;
				end
			end
		end
		cmd.count = n;
	end

	// advance control state on each transfer; take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= 3'd0;
			skip_q <= 1'b0;
			keep_q <= 1'b1;
		end else begin
			if (cfg_we) begin
				keep_q <= cfg_wdata;
			end
			if (accept) begin
				len_q  <= nxt_len;
				skip_q <= nxt_skip;
			end
		end
	end

	// hold the prefix characters
	always_ff @(posedge clk) begin
		if (accept) begin
			buf_q <= nxt_buf;
		end
	end

endmodule

`default_nettype wire

@@ rtl/xed_queue.sv @@
// Command queue: short FIFO between the front end and the back end.
`default_nettype none

module xed_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire xed_pkg::xed_cmd_t wr_cmd,
	output logic               full,
	input  wire logic          pop,
	output logic               head_valid,
	output xed_pkg::xed_cmd_t  head_cmd
);
	import xed_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	xed_cmd_t        mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_pop;

	assign full       = count_q == CW'(DEPTH);
	assign head_valid = count_q != '0;
	assign head_cmd   = mem_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// store commands
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

endmodule

`default_nettype wire

@@ rtl/xed_back.sv @@
// Back end: steps through the head command and presents one result per transfer.
`default_nettype none

module xed_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          head_valid,
	input  wire xed_pkg::xed_cmd_t head_cmd,
	output logic               pop,
	xed_out_if.source          results
);
	import xed_pkg::*;

	logic [2:0] idx_q;
	logic       at_last;
	logic       xfer;
	xed_item_t  item;

	assign item     = head_cmd.items[idx_q];
	assign at_last  = idx_q == head_cmd.count - 3'd1;
	assign xfer     = head_valid && results.ready;
	assign pop      = xfer && at_last;

	assign results.valid    = head_valid;
	assign results.out_char = item.ch;
	assign results.kind     = item.kind;
	assign results.last     = at_last;

	// advance to the next result, back to the start after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 3'd0;
		end else if (xfer) begin
			idx_q <= at_last ? 3'd0 : idx_q + 3'd1;
		end
	end

endmodule

`default_nettype wire

@@ rtl/xml_entity_decoder.sv @@
// Top level: XML predefined entity decoder, front end, command queue and back end.
//
//   channel   | role   | payload                         | transfer when
//   ----------+--------+---------------------------------+-----------------------
//   chars     | sink   | in_char[15:0], stop_char[15:0]  | valid && ready
//   results   | source | out_char[15:0], kind, last      | valid && ready
//   cfg       | write  | cfg_wdata (keep_whitespace)     | cfg_we
//
// A character is taken every cycle while the command queue has room; the front end
// turns it into a command of zero to six results in that cycle.
// While results.ready is high the back end gives one result a cycle, so a failed
// prefix of n characters gives up to n+1 results and the queue fills behind it.
// Reset clears the prefix length, the skipping flag and the queue; keep_whitespace
// comes out of reset as 1. The first result of a character can transfer in the
// cycle after that character.
`default_nettype none

module xml_entity_decoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	xed_in_if.sink     chars,
	xed_out_if.source  results,
	input  wire logic  cfg_we,
	input  wire logic  cfg_wdata
);
	import xed_pkg::*;

	logic     push, q_full, pop, head_valid;
	xed_cmd_t wr_cmd, head_cmd;

	// classify characters and keep the prefix state
	xed_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.chars     (chars),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_full    (q_full),
		.push      (push),
		.cmd       (wr_cmd)
	);

	// decouple the two sides
	xed_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.wr_cmd     (wr_cmd),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	// deliver results one by one
	xed_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.results    (results)
	);

endmodule

`default_nettype wire
